// File: rtl/efle_pkg.sv
package efle_pkg;

  localparam int WORD_BITS = 32;
  localparam int FREE_BITS = $clog2(WORD_BITS) + 1;
  localparam int LOW_BITS_W = $clog2(WORD_BITS);
  localparam int REP_BITS = 28;
  localparam int CFG_IDX_BITS = 1;

  localparam int SLOTS = 6;
  localparam int SLOT_BITS = $clog2(SLOTS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [FREE_BITS-1:0] free_t;
  typedef logic [SLOTS-1:0] slot_mask_t;
  typedef logic [SLOT_BITS-1:0] slot_t;

  localparam slot_t SLOT_LOWER = slot_t'(0);
  localparam slot_t SLOT_UPPER_PART = slot_t'(1);
  localparam slot_t SLOT_ZERO_RUN = slot_t'(2);
  localparam slot_t SLOT_UPPER_FULL = slot_t'(3);
  localparam slot_t SLOT_UPPER_FLUSH = slot_t'(4);
  localparam slot_t SLOT_LOWER_FLUSH = slot_t'(5);

  localparam logic [CFG_IDX_BITS-1:0] REG_LOW_BITS = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INVERT_UPPER = 1'b1;

  localparam free_t FREE_FULL = free_t'(WORD_BITS);

endpackage

// File: rtl/elias_fano_list_encoder.sv
// Flow: a request is held in the input register, then its results load a six-slot bank
// and leave it one at a time through the single result port.
// Throughput: one value per cycle while each value gives at most one result and res_stall
// is low; otherwise the next value waits in the input register until the bank has drained.
// Reset (rst, synchronous, active high) clears both streams and the previous high part,
// sets low_bits to 0 and invert_upper to 1; no clearing pass is needed.
module elias_fano_list_encoder (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [efle_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [efle_pkg::LOW_BITS_W-1:0]         cfg_data,
  input  logic                                    item_valid,
  output logic                                    item_stall,
  input  logic [efle_pkg::WORD_BITS-1:0]          value,
  input  logic                                    last_value,
  output logic                                    res_valid,
  input  logic                                    res_stall,
  output logic [efle_pkg::WORD_BITS-1:0]          word,
  output logic                                    stream_sel,
  output logic [efle_pkg::REP_BITS-1:0]           repeat_res,
  output logic                                    order_error,
  output logic                                    last_word
);
  import efle_pkg::*;

  logic [LOW_BITS_W-1:0] low_bits;
  logic                  invert_upper;

  logic  hold_valid;
  word_t hold_value;
  logic  hold_last;

  word_t prev_high;
  word_t lower_acc;
  free_t lower_free;
  word_t upper_acc;
  free_t upper_free;
  logic  err_pending;

  slot_mask_t            mask;
  word_t                 slot_word [SLOTS];
  logic [REP_BITS-1:0]   run;
  logic                  err;

  slot_mask_t            mask_next;
  word_t                 slot_word_next [SLOTS];
  logic [REP_BITS-1:0]   run_next;
  word_t                 prev_high_next;
  word_t                 lower_acc_next;
  free_t                 lower_free_next;
  word_t                 upper_acc_next;
  free_t                 upper_free_next;
  logic                  bad_order;

  word_t                 high;
  word_t                 low;
  word_t                 gap;
  logic [WORD_BITS:0]    gap1;
  word_t                 zeros;
  free_t                 w_ext;
  free_t                 rem;
  word_t                 inv_mask;

  slot_t                 sel;
  slot_mask_t            mask_taken;
  logic                  take;
  logic                  bank_free;
  logic                  advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_bits <= '0;
      invert_upper <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LOW_BITS:     low_bits <= cfg_data;
        REG_INVERT_UPPER: invert_upper <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // Encode the held value against the stream state.
  always_comb begin
    mask_next = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_word_next[i] = '0;
    end
    run_next = REP_BITS'(1);
    inv_mask = {WORD_BITS{invert_upper}};
    w_ext = free_t'(low_bits);
    high = hold_value >> low_bits;
    low = hold_value & ~({WORD_BITS{1'b1}} << low_bits);
    rem = '0;
    zeros = '0;

    bad_order = high < prev_high;
    gap = bad_order ? '0 : (high - prev_high);
    prev_high_next = bad_order ? prev_high : high;
    gap1 = {1'b0, gap} + (WORD_BITS+1)'(1);

    lower_acc_next = lower_acc;
    lower_free_next = lower_free;
    if (low_bits != '0) begin
      if (w_ext < lower_free) begin
        lower_acc_next = (lower_acc << low_bits) | low;
        lower_free_next = lower_free - w_ext;
      end else begin
        rem = w_ext - lower_free;
        mask_next[SLOT_LOWER] = 1'b1;
        slot_word_next[SLOT_LOWER] = (lower_acc << lower_free) | (low >> rem);
        lower_acc_next = low & ~({WORD_BITS{1'b1}} << rem);
        lower_free_next = FREE_FULL - rem;
      end
    end

    if (gap1 <= (WORD_BITS+1)'(upper_free)) begin
      upper_acc_next = (upper_acc << gap1[FREE_BITS-1:0]) | word_t'(1);
      upper_free_next = upper_free - gap1[FREE_BITS-1:0];
    end else begin
      if (upper_free >= FREE_FULL) begin
        zeros = gap;
      end else begin
        mask_next[SLOT_UPPER_PART] = 1'b1;
        slot_word_next[SLOT_UPPER_PART] = (upper_acc << upper_free) ^ inv_mask;
        zeros = gap - word_t'(upper_free);
      end
      run_next = REP_BITS'(zeros[WORD_BITS-1:LOW_BITS_W]);
      if (zeros[WORD_BITS-1:LOW_BITS_W] != '0) begin
        mask_next[SLOT_ZERO_RUN] = 1'b1;
        slot_word_next[SLOT_ZERO_RUN] = inv_mask;
      end
      upper_acc_next = word_t'(1);
      upper_free_next = FREE_FULL - free_t'(1) - free_t'(zeros[LOW_BITS_W-1:0]);
    end

    if (upper_free_next == '0) begin
      mask_next[SLOT_UPPER_FULL] = 1'b1;
      slot_word_next[SLOT_UPPER_FULL] = upper_acc_next ^ inv_mask;
      upper_acc_next = '0;
      upper_free_next = FREE_FULL;
    end

    if (hold_last) begin
      if (upper_free_next < FREE_FULL) begin
        mask_next[SLOT_UPPER_FLUSH] = 1'b1;
        slot_word_next[SLOT_UPPER_FLUSH] = (upper_acc_next << upper_free_next) ^ inv_mask;
      end
      mask_next[SLOT_LOWER_FLUSH] = 1'b1;
      slot_word_next[SLOT_LOWER_FLUSH] = (lower_free_next >= FREE_FULL) ? '0
                                       : (lower_acc_next << lower_free_next);
      prev_high_next = '0;
      lower_acc_next = '0;
      lower_free_next = FREE_FULL;
      upper_acc_next = '0;
      upper_free_next = FREE_FULL;
    end
  end

  // Pick the lowest pending slot.
  always_comb begin
    sel = SLOT_LOWER;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = slot_t'(i);
      end
    end
    mask_taken = mask;
    mask_taken[sel] = 1'b0;
  end

  assign res_valid = |mask;
  assign take = res_valid && !res_stall;
  assign bank_free = (mask == '0) || (take && (mask_taken == '0));
  assign advance = hold_valid && bank_free;
  assign item_stall = hold_valid && !advance;

  assign word = slot_word[sel];
  assign stream_sel = !((sel == SLOT_LOWER) || (sel == SLOT_LOWER_FLUSH));
  assign repeat_res = (sel == SLOT_ZERO_RUN) ? run : REP_BITS'(1);
  assign order_error = err;
  assign last_word = (sel == SLOT_LOWER_FLUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      hold_value <= value;
      hold_last <= last_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
      err <= 1'b0;
      err_pending <= 1'b0;
      prev_high <= '0;
      lower_acc <= '0;
      lower_free <= FREE_FULL;
      upper_acc <= '0;
      upper_free <= FREE_FULL;
    end else if (advance) begin
      mask <= mask_next;
      err <= (mask_next != '0) && (err_pending || bad_order);
      err_pending <= (mask_next == '0) && (err_pending || bad_order);
      prev_high <= prev_high_next;
      lower_acc <= lower_acc_next;
      lower_free <= lower_free_next;
      upper_acc <= upper_acc_next;
      upper_free <= upper_free_next;
    end else if (take) begin
      mask <= mask_taken;
      err <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_word[i] <= slot_word_next[i];
      end
      run <= run_next;
    end
  end

endmodule

// File: tb/elias_fano_list_encoder_test.sv
module elias_fano_list_encoder_test;
  import efle_pkg::*;

  localparam int TOTAL_VALUES = 310;
  localparam int HOLD_CYCLES = 80;
  localparam int REPORT_LIMIT = 10;
  localparam int DUE_DEPTH = 4096;
  localparam int FRESH_DEPTH = 8;

  typedef struct packed {
    word_t               data;
    logic                sel;
    logic [REP_BITS-1:0] reps;
    logic                err;
    logic                fin;
  } result_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_BITS-1:0] reg_idx;
    logic                    last;
    word_t                   value;
    logic [1:0]              npin;
    result_t                 pin_a;
    result_t                 pin_b;
  } row_t;

  localparam result_t NO_PIN = '0;
  localparam result_t LOWER_ZERO_LAST = '{32'h0, 1'b0, 28'd1, 1'b0, 1'b1};

  localparam int SCRIPT_LEN = 22;
  localparam row_t SCRIPT [SCRIPT_LEN] = '{
    '{ROW_ITEM, REG_LOW_BITS, 1'b1, 32'h0000_0000, 2'd2,
      '{32'h7FFF_FFFF, 1'b1, 28'd1, 1'b0, 1'b0}, LOWER_ZERO_LAST},
    '{ROW_ITEM, REG_LOW_BITS, 1'b0, 32'h0000_0005, 2'd0, NO_PIN, NO_PIN},
    '{ROW_ITEM, REG_LOW_BITS, 1'b1, 32'h0000_0003, 2'd2,
      '{32'hF9FF_FFFF, 1'b1, 28'd1, 1'b1, 1'b0}, LOWER_ZERO_LAST},
    '{ROW_ITEM, REG_LOW_BITS, 1'b0, 32'hFFFF_FFFF, 2'd0, NO_PIN, NO_PIN},
    '{ROW_ITEM, REG_LOW_BITS, 1'b1, 32'hFFFF_FFFF, 2'd0, NO_PIN, NO_PIN},
    '{ROW_REG, REG_INVERT_UPPER, 1'b0, 32'h0000_0000, 2'd0, NO_PIN, NO_PIN},
    '{ROW_ITEM, REG_LOW_BITS, 1'b1, 32'h0000_001F, 2'd2,
      '{32'h0000_0001, 1'b1, 28'd1, 1'b0, 1'b0}, LOWER_ZERO_LAST},
    '{ROW_ITEM, REG_LOW_BITS, 1'b0, 32'h0000_0028, 2'd0, NO_PIN, NO_PIN},
    '{ROW_ITEM, REG_LOW_BITS, 1'b0, 32'h0000_0032, 2'd0, NO_PIN, NO_PIN},
    '{ROW_ITEM, REG_LOW_BITS, 1'b0, 32'h0000_0014, 2'd0, NO_PIN, NO_PIN},
    '{ROW_ITEM, REG_LOW_BITS, 1'b1, 32'h0000_003C, 2'd0, NO_PIN, NO_PIN},
    '{ROW_REG, REG_LOW_BITS, 1'b0, 32'h0000_001F, 2'd0, NO_PIN, NO_PIN},
    '{ROW_ITEM, REG_LOW_BITS, 1'b0, 32'hFFFF_FFFF, 2'd0, NO_PIN, NO_PIN},
    '{ROW_ITEM, REG_LOW_BITS, 1'b0, 32'hFFFF_FFFF, 2'd0, NO_PIN, NO_PIN},
    '{ROW_ITEM, REG_LOW_BITS, 1'b1, 32'h0000_0000, 2'd0, NO_PIN, NO_PIN},
    '{ROW_REG, REG_LOW_BITS, 1'b0, 32'h0000_0010, 2'd0, NO_PIN, NO_PIN},
    '{ROW_REG, REG_INVERT_UPPER, 1'b0, 32'h0000_0001, 2'd0, NO_PIN, NO_PIN},
    '{ROW_ITEM, REG_LOW_BITS, 1'b0, 32'h0001_0000, 2'd0, NO_PIN, NO_PIN},
    '{ROW_ITEM, REG_LOW_BITS, 1'b0, 32'h0001_0001, 2'd0, NO_PIN, NO_PIN},
    '{ROW_ITEM, REG_LOW_BITS, 1'b0, 32'h0002_0000, 2'd0, NO_PIN, NO_PIN},
    '{ROW_ITEM, REG_LOW_BITS, 1'b0, 32'h0005_ABCD, 2'd0, NO_PIN, NO_PIN},
    '{ROW_ITEM, REG_LOW_BITS, 1'b1, 32'h8000_FFFF, 2'd0, NO_PIN, NO_PIN}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [LOW_BITS_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  word_t value = '0;
  logic last_value = 1'b0;
  logic res_valid;
  logic res_stall = 1'b0;
  word_t word;
  logic stream_sel;
  logic [REP_BITS-1:0] repeat_res;
  logic order_error;
  logic last_word;

  elias_fano_list_encoder u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .value      (value),
    .last_value (last_value),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .word       (word),
    .stream_sel (stream_sel),
    .repeat_res (repeat_res),
    .order_error(order_error),
    .last_word  (last_word)
  );

  always #2 clk = ~clk;

  int cfg_low_bits = 0;
  logic cfg_invert = 1'b1;
  word_t ef_prev_high = '0;
  word_t lo_acc = '0;
  int lo_free = WORD_BITS;
  word_t up_acc = '0;
  int up_free = WORD_BITS;
  logic err_held = 1'b0;

  result_t words_due [DUE_DEPTH];
  int due_head = 0;
  int due_tail = 0;
  result_t words_new [FRESH_DEPTH];
  int new_count = 0;
  int mismatches = 0;
  logic calm = 1'b0;
  logic want_hold = 1'b0;
  int sent = 0;

  function automatic void emit_word(input logic [63:0] w, input logic sel,
                                    input logic [63:0] reps, input logic fin);
    result_t r;
    r.data = (sel && cfg_invert) ? ~w[31:0] : w[31:0];
    r.sel = sel;
    r.reps = reps[REP_BITS-1:0];
    r.err = err_held;
    r.fin = fin;
    err_held = 1'b0;
    words_new[new_count] = r;
    new_count++;
  endfunction

  function automatic void add_due(input result_t r);
    words_due[due_tail % DUE_DEPTH] = r;
    due_tail++;
  endfunction

  function automatic void clear_lists();
    ef_prev_high = '0;
    lo_acc = '0;
    lo_free = WORD_BITS;
    up_acc = '0;
    up_free = WORD_BITS;
    err_held = 1'b0;
  endfunction

  function automatic void encode_value(input word_t v, input logic last);
    word_t high;
    word_t low;
    logic [63:0] gap;
    logic [63:0] zeros;
    logic [63:0] wd;
    int rem;
    int r_bits;
    high = v >> cfg_low_bits;
    low = v & word_t'((64'd1 << cfg_low_bits) - 64'd1);
    if (high < ef_prev_high) begin
      err_held = 1'b1;
      gap = '0;
    end else begin
      gap = {32'b0, high} - {32'b0, ef_prev_high};
      ef_prev_high = high;
    end
    if (cfg_low_bits != 0) begin
      if (cfg_low_bits < lo_free) begin
        lo_acc = word_t'(({32'b0, lo_acc} << cfg_low_bits) | {32'b0, low});
        lo_free = lo_free - cfg_low_bits;
      end else begin
        rem = cfg_low_bits - lo_free;
        wd = ({32'b0, lo_acc} << lo_free) | {32'b0, low >> rem};
        emit_word(wd, 1'b0, 64'd1, 1'b0);
        lo_acc = low & word_t'((64'd1 << rem) - 64'd1);
        lo_free = WORD_BITS - rem;
      end
    end
    if (gap + 64'd1 <= 64'(up_free)) begin
      up_acc = word_t'(({32'b0, up_acc} << (gap + 64'd1)) | 64'd1);
      up_free = up_free - int'(gap + 64'd1);
    end else begin
      if (up_free >= WORD_BITS) begin
        zeros = gap;
      end else begin
        emit_word({32'b0, up_acc} << up_free, 1'b1, 64'd1, 1'b0);
        zeros = gap - 64'(up_free);
      end
      r_bits = int'(zeros % 64'd32);
      if (zeros >= 64'd32)
        emit_word(64'd0, 1'b1, zeros / 64'd32, 1'b0);
      up_acc = 32'd1;
      up_free = WORD_BITS - r_bits - 1;
    end
    if (up_free == 0) begin
      emit_word({32'b0, up_acc}, 1'b1, 64'd1, 1'b0);
      up_acc = '0;
      up_free = WORD_BITS;
    end
    if (last) begin
      if (up_free < WORD_BITS)
        emit_word({32'b0, up_acc} << up_free, 1'b1, 64'd1, 1'b0);
      wd = (lo_free >= WORD_BITS) ? 64'd0 : ({32'b0, lo_acc} << lo_free);
      emit_word(wd, 1'b0, 64'd1, 1'b1);
      clear_lists();
    end
  endfunction

  task automatic send_item(input word_t v, input logic last, input logic [1:0] npin,
                           input result_t pin_a, input result_t pin_b);
    while (!calm && $urandom_range(0, 99) < 6) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    value <= v;
    last_value <= last;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    new_count = 0;
    encode_value(v, last);
    if (npin == 2'd0) begin
      for (int i = 0; i < new_count; i++) add_due(words_new[i]);
    end else begin
      add_due(pin_a);
      if (npin == 2'd2) add_due(pin_b);
    end
    sent++;
  endtask

  task automatic await_drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (due_head != due_tail) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [LOW_BITS_W-1:0] data);
    await_drain();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_LOW_BITS)
      cfg_low_bits = int'(data);
    else
      cfg_invert = data[0];
  endtask

  initial begin : receiver
    int hold_left = 0;
    forever begin
      @(posedge clk);
      if (want_hold) begin
        want_hold = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= !calm && ($urandom_range(0, 99) < 6);
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (due_head == due_tail) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: word %h sel %b rep %0d err %b last %b",
                   word, stream_sel, repeat_res, order_error, last_word);
      end else begin
        want = words_due[due_head % DUE_DEPTH];
        due_head++;
        if (word !== want.data || stream_sel !== want.sel || repeat_res !== want.reps ||
            order_error !== want.err || last_word !== want.fin) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch: exp %h %b %0d %b %b got %h %b %0d %b %b",
                     want.data, want.sel, want.reps, want.err, want.fin,
                     word, stream_sel, repeat_res, order_error, last_word);
        end
      end
    end
  end

  initial begin
    #400000;
    $display("elias_fano_list_encoder_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    int len;
    word_t cur;
    word_t v;
    logic [32:0] nxt;
    logic [LOW_BITS_W-1:0] lb;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == ROW_REG)
        write_reg(SCRIPT[i].reg_idx, SCRIPT[i].value[LOW_BITS_W-1:0]);
      else
        send_item(SCRIPT[i].value, SCRIPT[i].last, SCRIPT[i].npin,
                  SCRIPT[i].pin_a, SCRIPT[i].pin_b);
    end

    while (sent < TOTAL_VALUES) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 9))
          0: lb = '0;
          1: lb = '1;
          default: lb = LOW_BITS_W'($urandom_range(1, 30));
        endcase
        write_reg(REG_LOW_BITS, lb);
        if ($urandom_range(0, 1) == 0)
          write_reg(REG_INVERT_UPPER, LOW_BITS_W'($urandom_range(0, 1)));
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      cur = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
      for (int k = 0; k < len && sent < TOTAL_VALUES; k++) begin
        calm = (sent >= 150 && sent < 210);
        if (sent == 100) want_hold = 1'b1;
        if (sent == 240) await_drain();
        case ($urandom_range(0, 9))
          0, 1, 2, 3: nxt = {1'b0, cur} + 33'($urandom_range(0, 3));
          4, 5, 6: nxt = {1'b0, cur} + 33'($urandom_range(0, 1 << (cfg_low_bits % 20 + 6)));
          7: nxt = {1'b0, cur} + 33'($urandom_range(0, 1 << 24));
          8: nxt = {1'b0, cur} + {1'b0, $urandom};
          default: nxt = {1'b1, cur};
        endcase
        if (nxt[32] && nxt != {1'b1, cur})
          cur = '1;
        else if (!nxt[32])
          cur = nxt[31:0];
        v = nxt[32] && nxt == {1'b1, cur} ? word_t'($urandom) : cur;
        send_item(v, (k == len - 1) || (sent == TOTAL_VALUES - 1), 2'd0, NO_PIN, NO_PIN);
      end
    end

    calm = 1'b0;
    await_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("elias_fano_list_encoder_test: PASS");
    else
      $display("elias_fano_list_encoder_test: FAIL");
    $finish;
  end

endmodule
